// ===== rtl/base64_stream_decoder_top_macros.svh =====
// Assertion macros shared by the checker of the Base64 stream decoder.
// Each macro expands to one labeled concurrent assertion on clk, held off in reset.
`ifndef BASE64_STREAM_DECODER_TOP_MACROS_SVH
`define BASE64_STREAM_DECODER_TOP_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define B64D_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define B64D_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/b64d_pkg.sv =====
// Package of the Base64 stream decoder: character codes, status codes, queue sizes,
// the record type passed from front to back, and the alphabet lookup. No dependencies.
`timescale 1ns / 1ps

package b64d_pkg;

  localparam logic [7:0] CHAR_UPPER_A = 8'h41;
  localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
  localparam logic [7:0] CHAR_LOWER_A = 8'h61;
  localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
  localparam logic [7:0] CHAR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHAR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHAR_PLUS    = 8'h2B;
  localparam logic [7:0] CHAR_SLASH   = 8'h2F;
  localparam logic [7:0] CHAR_PAD     = 8'h3D;

  localparam logic [5:0] SEXTET_LOWER_BASE = 6'd26;
  localparam logic [5:0] SEXTET_DIGIT_BASE = 6'd52;
  localparam logic [5:0] SEXTET_PLUS       = 6'h3E;
  localparam logic [5:0] SEXTET_SLASH      = 6'h3F;

  localparam logic [1:0] POS_LAST   = 2'd3;
  localparam logic [1:0] PAD_MAX    = 2'd2;
  localparam logic [1:0] QUAD_BYTES = 2'd3;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);
  localparam int QCNT_W = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_INVALID = 2'd1,
    STATUS_LENGTH  = 2'd2
  } status_t;

  typedef struct packed {
    logic       invalid;
    logic [5:0] value;
  } sextet_t;

  typedef struct packed {
    logic [23:0] trip;
    logic [1:0]  nres;
    logic        last;
    status_t     status;
    logic [1:0]  pads;
    logic        data_ok;
  } rec_t;

  function automatic sextet_t sextet_of(input logic [7:0] c);
    sextet_t r;
    r.invalid = 1'b0;
    r.value   = '0;
    priority if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
      r.value = 6'(c - CHAR_UPPER_A);
    end else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
      r.value = 6'(c - CHAR_LOWER_A) + SEXTET_LOWER_BASE;
    end else if (c >= CHAR_DIGIT_0 && c <= CHAR_DIGIT_9) begin
      r.value = 6'(c - CHAR_DIGIT_0) + SEXTET_DIGIT_BASE;
    end else if (c == CHAR_PLUS) begin
      r.value = SEXTET_PLUS;
    end else if (c == CHAR_SLASH) begin
      r.value = SEXTET_SLASH;
    end else if (c == CHAR_PAD) begin
      r.value = '0;
    end else begin
      r.invalid = 1'b1;
    end
    return r;
  endfunction

endpackage

// ===== rtl/b64d_front.sv =====
// Front of the Base64 stream decoder: takes characters, keeps the quad state and pushes one record per
// stream end and per finished quad while the stream has no invalid character. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_front (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_tvalid,
  output logic            in_tready,
  input  logic [7:0]      in_tdata,
  input  logic            in_tlast,
  input  logic            q_full,
  output logic            push,
  output b64d_pkg::rec_t  push_rec
);

  logic [17:0] accum_r, accum_nxt;
  logic [1:0]  pos_r, pos_nxt;
  logic [1:0]  pad_r, pad_nxt;
  logic        err_r, err_nxt;

  b64d_pkg::sextet_t sx;
  logic [1:0]  pad_upd;
  logic        err_upd;
  logic        accept;

  assign in_tready = !q_full;
  assign accept    = in_tvalid && in_tready;
  assign sx        = b64d_pkg::sextet_of(in_tdata);
  assign pad_upd   = (in_tdata == b64d_pkg::CHAR_PAD && pad_r != b64d_pkg::PAD_MAX) ?
                     pad_r + 2'd1 : pad_r;
  assign err_upd   = err_r | sx.invalid;

  always_comb begin
    accum_nxt        = accum_r;
    pos_nxt          = pos_r;
    pad_nxt          = pad_r;
    err_nxt          = err_r;
    push             = 1'b0;
    push_rec.trip    = {accum_r, sx.value};
    push_rec.nres    = b64d_pkg::QUAD_BYTES;
    push_rec.last    = 1'b0;
    push_rec.status  = b64d_pkg::STATUS_OK;
    push_rec.pads    = '0;
    push_rec.data_ok = 1'b1;
    if (accept) begin
      if (in_tlast) begin
        accum_nxt     = '0;
        pos_nxt       = '0;
        pad_nxt       = '0;
        err_nxt       = 1'b0;
        push          = 1'b1;
        push_rec.last = 1'b1;
        push_rec.pads = pad_upd;
        if (pos_r != b64d_pkg::POS_LAST) begin
          push_rec.trip    = '0;
          push_rec.nres    = 2'd1;
          push_rec.status  = b64d_pkg::STATUS_LENGTH;
          push_rec.data_ok = 1'b0;
        end else if (err_upd) begin
          push_rec.trip    = '0;
          push_rec.nres    = 2'd1;
          push_rec.status  = b64d_pkg::STATUS_INVALID;
          push_rec.data_ok = 1'b0;
        end else begin
          push_rec.nres = b64d_pkg::QUAD_BYTES - pad_upd;
        end
      end else begin
        pad_nxt = pad_upd;
        err_nxt = err_upd;
        pos_nxt = pos_r + 2'd1;
        if (pos_r == b64d_pkg::POS_LAST) begin
          accum_nxt = '0;
          push      = !err_upd;
        end else begin
          accum_nxt = {accum_r[11:0], sx.value};
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accum_r <= '0;
      pos_r   <= '0;
      pad_r   <= '0;
      err_r   <= 1'b0;
    end else begin
      accum_r <= accum_nxt;
      pos_r   <= pos_nxt;
      pad_r   <= pad_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

// ===== rtl/b64d_queue.sv =====
// Short record queue between the front and the back of the Base64 stream decoder.
// Depends on b64d_pkg for the record type and the depth.
`timescale 1ns / 1ps

module b64d_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push,
  input  b64d_pkg::rec_t  push_rec,
  output logic            full,
  input  logic            pop,
  output logic            not_empty,
  output b64d_pkg::rec_t  pop_rec
);

  b64d_pkg::rec_t                  mem_r [b64d_pkg::QDEPTH];
  logic [b64d_pkg::QPTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [b64d_pkg::QPTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [b64d_pkg::QCNT_W-1:0]     count_r, count_nxt;

  assign full      = count_r == b64d_pkg::QCNT_W'(b64d_pkg::QDEPTH);
  assign not_empty = count_r != '0;
  assign pop_rec   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == b64d_pkg::QPTR_W'(b64d_pkg::QDEPTH - 1)) ? '0 :
                   wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == b64d_pkg::QPTR_W'(b64d_pkg::QDEPTH - 1)) ? '0 :
                   rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_rec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

// ===== rtl/b64d_back.sv =====
// Back of the Base64 stream decoder: takes records from the queue and sends their
// result words one per cycle through an output register while the output is not stalled. Depends on b64d_pkg.
`timescale 1ns / 1ps

module b64d_back (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            q_not_empty,
  input  b64d_pkg::rec_t  q_rec,
  output logic            pop,
  output logic            out_tvalid,
  input  logic            out_tready,
  output logic [15:0]     out_tdata,
  output logic            out_tlast,
  output logic [2:0]      out_tuser
);

  b64d_pkg::rec_t cur_r, cur_nxt;
  logic           cur_valid_r, cur_valid_nxt;
  logic [1:0]     idx_r, idx_nxt;

  logic           ov_r, ov_nxt;
  logic [7:0]     obyte_r, obyte_nxt;
  logic           olast_r, olast_nxt;
  logic [1:0]     ostat_r, ostat_nxt;
  logic [1:0]     opad_r, opad_nxt;
  logic           obv_r, obv_nxt;

  logic           load_ok;
  logic           emit;
  logic           fin;
  logic [7:0]     sel_byte;

  assign load_ok = !ov_r || out_tready;
  assign emit    = cur_valid_r && load_ok;
  assign fin     = idx_r == (cur_r.nres - 2'd1);
  assign pop     = q_not_empty && (!cur_valid_r || (emit && fin));

  always_comb begin
    unique case (idx_r)
      2'd0:    sel_byte = cur_r.trip[23:16];
      2'd1:    sel_byte = cur_r.trip[15:8];
      default: sel_byte = cur_r.trip[7:0];
    endcase
  end

  always_comb begin
    cur_nxt       = cur_r;
    cur_valid_nxt = cur_valid_r;
    idx_nxt       = idx_r;
    if (pop) begin
      cur_nxt       = q_rec;
      cur_valid_nxt = 1'b1;
      idx_nxt       = '0;
    end else if (emit && fin) begin
      cur_valid_nxt = 1'b0;
    end else if (emit) begin
      idx_nxt = idx_r + 2'd1;
    end
  end

  always_comb begin
    ov_nxt    = ov_r;
    obyte_nxt = obyte_r;
    olast_nxt = olast_r;
    ostat_nxt = ostat_r;
    opad_nxt  = opad_r;
    obv_nxt   = obv_r;
    if (emit) begin
      ov_nxt    = 1'b1;
      obyte_nxt = cur_r.data_ok ? sel_byte : 8'd0;
      olast_nxt = cur_r.last && fin;
      ostat_nxt = cur_r.status;
      opad_nxt  = fin ? cur_r.pads : 2'd0;
      obv_nxt   = cur_r.data_ok;
    end else if (out_tready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_valid_r <= 1'b0;
      idx_r       <= '0;
      ov_r        <= 1'b0;
    end else begin
      cur_valid_r <= cur_valid_nxt;
      idx_r       <= idx_nxt;
      ov_r        <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r   <= cur_nxt;
    obyte_r <= obyte_nxt;
    olast_r <= olast_nxt;
    ostat_r <= ostat_nxt;
    opad_r  <= opad_nxt;
    obv_r   <= obv_nxt;
  end

  assign out_tvalid = ov_r;
  assign out_tdata  = {6'd0, opad_r, obyte_r};
  assign out_tlast  = olast_r;
  assign out_tuser  = {obv_r, ostat_r};

endmodule

// ===== rtl/base64_stream_decoder_top.sv =====
// Base64 stream decoder: one character word in, up to three byte words out per quad.
// With the back idle, the first result word of a record goes from the queue memory through cur_r
// into the output register, and the rest follow one per cycle while the output is not stalled.
// Throughput: one character per cycle while the queue is not full; results leave at one word per cycle unless stalled.
// The record queue holds four records, so input stalls only while a stalled output fills it.
// Reset: synchronous active-low rst_n clears quad state, queue and output register.
`timescale 1ns / 1ps

module base64_stream_decoder_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] data_byte, [9:8] pad_total, [15:10] zero
  output logic        out_tlast,
  output logic [2:0]  out_tuser   // [1:0] status, [2] byte_valid
);

  logic           q_full;
  logic           q_push;
  logic           q_pop;
  logic           q_not_empty;
  b64d_pkg::rec_t q_push_rec;
  b64d_pkg::rec_t q_pop_rec;

  b64d_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .q_full    (q_full),
    .push      (q_push),
    .push_rec  (q_push_rec)
  );

  b64d_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_rec  (q_push_rec),
    .full      (q_full),
    .pop       (q_pop),
    .not_empty (q_not_empty),
    .pop_rec   (q_pop_rec)
  );

  b64d_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_rec       (q_pop_rec),
    .pop         (q_pop),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tlast   (out_tlast),
    .out_tuser   (out_tuser)
  );

endmodule

// ===== rtl/b64d_checker.sv =====
// Port checker of the Base64 stream decoder and its bind to the top level.
// Depends on base64_stream_decoder_top_macros.svh and on b64d_pkg.
`timescale 1ns / 1ps
`include "base64_stream_decoder_top_macros.svh"

module b64d_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tlast,
  input logic [2:0]  out_tuser
);

  logic [1:0]  o_stat;
  logic        o_bv;
  logic [7:0]  o_byte;
  logic [1:0]  o_pads;
  logic [19:0] out_word;
  logic        err_word;
  logic        err_ok;
  logic        stat_word;
  logic        stat_ok;
  logic        pad_word;
  logic        pad_ok;
  logic        out_wait;

  assign o_stat    = out_tuser[1:0];
  assign o_bv      = out_tuser[2];
  assign o_byte    = out_tdata[7:0];
  assign o_pads    = out_tdata[9:8];
  assign out_word  = {out_tlast, out_tuser, out_tdata};
  assign err_word  = out_tvalid && o_stat != b64d_pkg::STATUS_OK;
  assign err_ok    = out_tlast && !o_bv && (o_stat == b64d_pkg::STATUS_INVALID ||
                                             o_stat == b64d_pkg::STATUS_LENGTH);
  assign stat_word = out_tvalid && !o_bv;
  assign stat_ok   = out_tlast && o_byte == 8'd0 && o_stat != b64d_pkg::STATUS_OK;
  assign pad_word  = out_tvalid && o_pads != 2'd0;
  assign pad_ok    = out_tlast && o_pads <= b64d_pkg::PAD_MAX;
  assign out_wait  = out_tvalid && !out_tready;

  `B64D_ASSERT_SAME(a_status_ends, err_word, err_ok, "error status on a non-final word")
  `B64D_ASSERT_SAME(a_nobyte_zero, stat_word, stat_ok, "word without a byte is malformed")
  `B64D_ASSERT_SAME(a_pads_on_last, pad_word, pad_ok, "pad count misplaced or too large")
  `B64D_ASSERT_NEXT(a_out_hold, out_wait, out_tvalid && $stable(out_word), "stalled word changed")

endmodule

bind base64_stream_decoder_top b64d_checker u_b64d_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast),
  .out_tuser  (out_tuser)
);

// ===== sim/tb_base64_stream_decoder_top.sv =====
// Self-checking testbench for base64_stream_decoder_top: sends character words,
// predicts every decoded or status word, and checks them in order on the output stream.
// Depends on b64d_pkg and on the top level in rtl.
`timescale 1ns / 1ps

module tb_base64_stream_decoder_top;

  localparam int CYCLE_LIMIT = 200_000;

  typedef struct packed {
    logic [7:0]        data;
    logic              last;
    b64d_pkg::status_t status;
    logic [1:0]        pads;
    logic              valid;
  } dec_word_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;   // [7:0] char_in
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;          // [7:0] data_byte, [9:8] pad_total, [15:10] zero
  logic        out_tlast;
  logic [2:0]  out_tuser;          // [1:0] status, [2] byte_valid

  dec_word_t   decoded_words_due[$];
  dec_word_t   got_word;
  dec_word_t   want_word;

  logic [17:0] quad_bits;
  logic [1:0]  quad_pos;
  logic [1:0]  pad_tally;
  logic        bad_char_seen;

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned hold_request;
  int unsigned hold_left;
  int unsigned cycle_count;
  int unsigned error_count;
  int unsigned items_sent;
  int unsigned streams_sent;
  int unsigned words_checked;
  int unsigned input_stall_cycles;

  base64_stream_decoder_top u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (in_tvalid && !in_tready) begin
      input_stall_cycles++;
    end
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timed out after %0d cycles with %0d words outstanding.", cycle_count,
               decoded_words_due.size());
      $display("FAIL");
      $finish;
    end
  end

  // Receiver: random stalls, or a long hold-off when one is requested.
  always @(posedge clk) begin
    if (hold_request != 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left != 0) begin
      out_tready <= 1'b0;
      hold_left--;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic logic [6:0] char_sextet(input logic [7:0] c);
    logic [7:0] off;
    off = 8'h00;
    if (c >= b64d_pkg::CHAR_UPPER_A && c <= b64d_pkg::CHAR_UPPER_Z) begin
      off = c - b64d_pkg::CHAR_UPPER_A;
    end else if (c >= b64d_pkg::CHAR_LOWER_A && c <= b64d_pkg::CHAR_LOWER_Z) begin
      off = c - b64d_pkg::CHAR_LOWER_A + b64d_pkg::SEXTET_LOWER_BASE;
    end else if (c >= b64d_pkg::CHAR_DIGIT_0 && c <= b64d_pkg::CHAR_DIGIT_9) begin
      off = c - b64d_pkg::CHAR_DIGIT_0 + b64d_pkg::SEXTET_DIGIT_BASE;
    end else if (c == b64d_pkg::CHAR_PLUS) begin
      off = b64d_pkg::SEXTET_PLUS;
    end else if (c == b64d_pkg::CHAR_SLASH) begin
      off = b64d_pkg::SEXTET_SLASH;
    end else if (c != b64d_pkg::CHAR_PAD) begin
      return 7'h40;
    end
    return {1'b0, off[5:0]};
  endfunction

  function automatic void push_word(input logic [7:0] data, input logic last,
                                    input b64d_pkg::status_t status, input logic [1:0] pads,
                                    input logic valid);
    dec_word_t w;
    w.data   = data;
    w.last   = last;
    w.status = status;
    w.pads   = pads;
    w.valid  = valid;
    decoded_words_due = {decoded_words_due, w};
  endfunction

  task automatic decode_char(input logic [7:0] c, input logic close);
    logic [6:0]  sx;
    logic [23:0] trip;
    int          nbytes;
    sx = char_sextet(c);
    if (c == b64d_pkg::CHAR_PAD && pad_tally < b64d_pkg::PAD_MAX) begin
      pad_tally++;
    end
    if (sx[6]) begin
      bad_char_seen = 1'b1;
    end
    trip = {quad_bits, (sx[6] ? 6'd0 : sx[5:0])};
    if (close) begin
      if (quad_pos != b64d_pkg::POS_LAST) begin
        push_word(8'h00, 1'b1, b64d_pkg::STATUS_LENGTH, pad_tally, 1'b0);
      end else if (bad_char_seen) begin
        push_word(8'h00, 1'b1, b64d_pkg::STATUS_INVALID, pad_tally, 1'b0);
      end else begin
        nbytes = int'(b64d_pkg::QUAD_BYTES - pad_tally);
        for (int i = 0; i < nbytes; i++) begin
          push_word(trip[23 - 8 * i -: 8], (i == nbytes - 1), b64d_pkg::STATUS_OK,
                    (i == nbytes - 1) ? pad_tally : 2'd0, 1'b1);
        end
      end
      quad_bits = '0;
      quad_pos = '0;
      pad_tally = '0;
      bad_char_seen = 1'b0;
    end else begin
      if (quad_pos == b64d_pkg::POS_LAST) begin
        if (!bad_char_seen) begin
          for (int i = 0; i < b64d_pkg::QUAD_BYTES; i++) begin
            push_word(trip[23 - 8 * i -: 8], 1'b0, b64d_pkg::STATUS_OK, 2'd0, 1'b1);
          end
        end
        quad_bits = '0;
      end else begin
        quad_bits = trip[17:0];
      end
      quad_pos++;
    end
  endtask

  task automatic send_char(input logic [7:0] c, input logic close);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= c;
    in_tlast  <= close;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    decode_char(c, close);
    items_sent++;
  endtask

  task automatic send_text(input string s, input logic close);
    for (int i = 0; i < s.len(); i++) begin
      send_char(s[i], close && (i == s.len() - 1));
    end
    if (close) begin
      streams_sent++;
    end
  endtask

  function automatic logic [7:0] random_b64_char();
    logic [7:0] k;
    k = 8'($urandom_range(63));
    if (k < b64d_pkg::SEXTET_LOWER_BASE) begin
      return b64d_pkg::CHAR_UPPER_A + k;
    end else if (k < b64d_pkg::SEXTET_DIGIT_BASE) begin
      return b64d_pkg::CHAR_LOWER_A + k - b64d_pkg::SEXTET_LOWER_BASE;
    end else if (k < b64d_pkg::SEXTET_PLUS) begin
      return b64d_pkg::CHAR_DIGIT_0 + k - b64d_pkg::SEXTET_DIGIT_BASE;
    end else if (k == b64d_pkg::SEXTET_PLUS) begin
      return b64d_pkg::CHAR_PLUS;
    end
    return b64d_pkg::CHAR_SLASH;
  endfunction

  function automatic logic [7:0] random_bad_char();
    logic [7:0] c;
    logic [6:0] sx;
    do begin
      c = 8'($urandom_range(255));
      sx = char_sextet(c);
    end while (!sx[6]);
    return c;
  endfunction

  // Well-formed text with the final pads in place, or one of several broken shapes.
  task automatic send_random_stream(input int quads, input bit allow_faults);
    logic [7:0] text[$];
    int         pads;
    int         shape;
    int         keep;
    for (int i = 0; i < quads * 4; i++) begin
      text = {text, random_b64_char()};
    end
    pads = $urandom_range(2);
    for (int i = 0; i < pads; i++) begin
      text[text.size() - 1 - i] = b64d_pkg::CHAR_PAD;
    end
    shape = allow_faults ? $urandom_range(99) : 99;
    if (shape < 10) begin
      text[$urandom_range(text.size() - 1)] = random_bad_char();
    end else if (shape < 20) begin
      keep = text.size() - $urandom_range(1, 3);
      if (keep < 1) begin
        keep = 1;
      end
      while (text.size() > keep) void'(text.pop_back());
    end else if (shape < 27) begin
      text[$urandom_range(text.size() - 1)] = b64d_pkg::CHAR_PAD;
    end else if (shape < 35) begin
      text.delete();
      repeat ($urandom_range(1, 12)) text = {text, 8'($urandom_range(255))};
    end
    for (int i = 0; i < text.size(); i++) begin
      send_char(text[i], i == text.size() - 1);
    end
    streams_sent++;
  endtask

  task automatic wait_for_drain();
    in_tvalid <= 1'b0;
    while (decoded_words_due.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed_cases();
    send_text("+/9z", 1'b0);
    send_text("TWFu", 1'b1);
    // A pad inside an inner quad, then the pad count saturating at two.
    send_text("AB=C", 1'b0);
    send_text("za==", 1'b1);
    send_text("QUI=", 1'b1);
    // Invalid characters at both ends of the byte range.
    send_char(8'hFF, 1'b0);
    send_char(8'h00, 1'b0);
    send_text("AB", 1'b1);
    // A short stream reports length even after an invalid character.
    send_char(8'h80, 1'b0);
    send_text("A", 1'b1);
    send_text("ABC", 1'b1);
    wait_for_drain();
  endtask

  task automatic test_random_streams(input int unsigned target);
    int unsigned start;
    start = items_sent;
    while (items_sent - start < target) begin
      send_random_stream(($urandom_range(7) == 0) ? $urandom_range(4, 6) : $urandom_range(1, 3),
                         1'b1);
    end
    wait_for_drain();
  endtask

  task automatic test_output_backpressure();
    hold_request = 300;
    repeat (3) send_random_stream(6, 1'b0);
    wait_for_drain();
  endtask

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      got_word.data   = out_tdata[7:0];
      got_word.last   = out_tlast;
      got_word.status = b64d_pkg::status_t'(out_tuser[1:0]);
      got_word.pads   = out_tdata[9:8];
      got_word.valid  = out_tuser[2];
      if (decoded_words_due.size() == 0) begin
        $error("Unexpected output word: data_byte %0h, last_out %0b, status %0d",
               got_word.data, got_word.last, got_word.status);
        error_count++;
      end else begin
        want_word = decoded_words_due.pop_front();
        if (got_word.data !== want_word.data) begin
          $error("data_byte: expected %0h, actual %0h", want_word.data, got_word.data);
          error_count++;
        end
        if (got_word.last !== want_word.last) begin
          $error("last_out: expected %0b, actual %0b", want_word.last, got_word.last);
          error_count++;
        end
        if (got_word.status !== want_word.status) begin
          $error("status: expected %0d, actual %0d", want_word.status, got_word.status);
          error_count++;
        end
        if (got_word.pads !== want_word.pads) begin
          $error("pad_total: expected %0d, actual %0d", want_word.pads, got_word.pads);
          error_count++;
        end
        if (got_word.valid !== want_word.valid) begin
          $error("byte_valid: expected %0b, actual %0b", want_word.valid, got_word.valid);
          error_count++;
        end
      end
      words_checked++;
    end
  end

  initial begin
    quad_bits = '0;
    quad_pos = '0;
    pad_tally = '0;
    bad_char_seen = 1'b0;
    hold_request = 0;
    hold_left = 0;
    send_idle_pct = 27;
    recv_idle_pct = 73;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_cases();
    test_random_streams(140);
    send_idle_pct = 73;
    recv_idle_pct = 27;
    test_random_streams(140);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_streams(140);
    test_output_backpressure();
    in_tvalid <= 1'b0;
    repeat (10) @(posedge clk);
    $display("Decoded %0d streams of %0d characters into %0d checked words.",
             streams_sent, items_sent, words_checked);
    $display("Input was held off for %0d cycles; %0d mismatches found.",
             input_stall_cycles, error_count);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
